// ===== rtl/bis_pkg.sv =====
package bis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 32;
    localparam int CMP_W     = 9;
    localparam int MOV_W     = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SHIFT,
        ST_DRAIN,
        ST_INSERT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } bis_state_t;

endpackage

// ===== rtl/binary_insertion_sorter_unit.sv =====
// Stable binary insertion sorter. Each key transfer on s_axis is inserted into a
// 64-entry sorted memory (simple dual-port RAM, one read and one write per cycle,
// registered read); s_axis_tlast closes the set, after which the whole set
// leaves on m_axis in ascending signed order, the last transfer carrying the
// comparison count, the move count and the overflow flag, after which the store
// and counts clear. Per key: accept, then search probes (at most 6), each a read
// then a compare, then a shift pass that moves each entry above the insertion
// point up by one, a drain write, and a write to place the key; the shift pass
// through the RAM dominates. s_axis_tready is high only while idle, so the next key
// waits until the current one is placed. Emission reads each key, then presents
// it. A key that arrives with the store full is dropped and flagged.
module binary_insertion_sorter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] key
    input  logic [bis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] sorted_key, [40:32] compare_count, [51:41] move_count,
    // [52] overflowed, [55:53] zero
    output logic [bis_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import bis_pkg::*;

    bis_state_t state_reg, state_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic               final_reg, final_next;
    logic [COUNT_W-1:0] item_count_reg, item_count_next;
    logic [CMP_W-1:0]   compare_total_reg, compare_total_next;
    logic [MOV_W-1:0]   move_total_reg, move_total_next;
    logic               drop_flag_reg, drop_flag_next;
    logic [COUNT_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               pend_reg, pend_next;

    // sorted store
    logic [KEY_W-1:0]   mem [MAX_ITEMS];
    logic [KEY_W-1:0]   rd_data_reg;
    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
    logic [KEY_W-1:0]   mem_wdata;

    logic               in_xfer, out_xfer, store_full, key_lt, emit_last;
    logic [COUNT_W:0]   mid_sum;
    logic [COUNT_W-1:0] lo_upd, hi_upd;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign store_full = (item_count_reg == COUNT_W'(MAX_ITEMS));
    assign key_lt     = $signed(key_reg) < $signed(rd_data_reg);
    assign emit_last  = (COUNT_W'(ptr_reg) + COUNT_W'(1)) == item_count_reg;
    assign lo_upd     = key_lt ? lo_reg : (COUNT_W'(mid_reg) + COUNT_W'(1));
    assign hi_upd     = key_lt ? COUNT_W'(mid_reg) : hi_reg;
    // next probe: (lo + hi - 1) / 2 over the narrowed range
    assign mid_sum    = ({1'b0, lo_upd} + {1'b0, hi_upd} - (COUNT_W+1)'(1)) >> 1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (store_full)
                        state_next = s_axis_tlast ? ST_EMIT_RD : ST_IDLE;
                    else if (item_count_reg != '0)
                        state_next = ST_PROBE;
                    else
                        state_next = ST_INSERT;
                end
            end
            ST_PROBE:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (lo_upd < hi_upd)
                    state_next = ST_PROBE;
                else if (lo_upd < item_count_reg)
                    state_next = ST_SHIFT;
                else
                    state_next = ST_INSERT;
            end
            ST_SHIFT:
                if (COUNT_W'(ptr_reg) == lo_reg)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_INSERT;
            ST_INSERT:
                state_next = final_reg ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD:
                state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
                if (out_xfer)
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // handshake and memory controls
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg;
        mem_we        = 1'b0;
        mem_waddr     = pend_addr_reg;
        mem_wdata     = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_PROBE:
            begin
                mem_re    = 1'b1;
                mem_raddr = mid_reg;
            end
            ST_SHIFT:
            begin
                mem_re = 1'b1;
                mem_we = pend_reg;
            end
            ST_DRAIN:
                mem_we = 1'b1;
            ST_INSERT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(lo_reg);
                mem_wdata = key_reg;
            end
            ST_EMIT_RD:
                mem_re = 1'b1;
            ST_EMIT_OUT:
                m_axis_tvalid = 1'b1;
            default:
                ;
        endcase
    end

    assign m_axis_tlast = emit_last;
    assign m_axis_tdata = {3'b000,
                           emit_last && drop_flag_reg,
                           emit_last ? move_total_reg : MOV_W'(0),
                           emit_last ? compare_total_reg : CMP_W'(0),
                           rd_data_reg};

    // datapath
    always_comb
    begin
        key_next           = key_reg;
        final_next         = final_reg;
        item_count_next    = item_count_reg;
        compare_total_next = compare_total_reg;
        move_total_next    = move_total_reg;
        drop_flag_next     = drop_flag_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        ptr_next           = ptr_reg;
        pend_addr_next     = pend_addr_reg;
        pend_next          = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    key_next   = s_axis_tdata[KEY_W-1:0];
                    final_next = s_axis_tlast;
                    lo_next    = '0;
                    hi_next    = item_count_reg;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    // first probe: (0 + count - 1) / 2
                    mid_next   = ADDR_W'((item_count_reg - COUNT_W'(1)) >> 1);
                    if (store_full)
                        drop_flag_next = 1'b1;
                end
            end
            ST_PROBE:
                ;
            ST_CMP:
            begin
                lo_next            = lo_upd;
                hi_next            = hi_upd;
                compare_total_next = compare_total_reg + CMP_W'(1);
                mid_next           = ADDR_W'(mid_sum);
                ptr_next           = ADDR_W'(item_count_reg - COUNT_W'(1));
            end
            ST_SHIFT:
            begin
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg + ADDR_W'(1);
                if (COUNT_W'(ptr_reg) != lo_reg)
                    ptr_next = ptr_reg - ADDR_W'(1);
            end
            ST_DRAIN:
                pend_next = 1'b0;
            ST_INSERT:
            begin
                // totals cannot reach their maxima for up to 64 keys
                move_total_next = move_total_reg + MOV_W'(item_count_reg - lo_reg);
                item_count_next = item_count_reg + COUNT_W'(1);
                ptr_next        = '0;
            end
            ST_EMIT_OUT:
            begin
                if (out_xfer)
                begin
                    if (emit_last)
                    begin
                        item_count_next    = '0;
                        compare_total_next = '0;
                        move_total_next    = '0;
                        drop_flag_next     = 1'b0;
                    end
                    else
                        ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            item_count_reg    <= '0;
            compare_total_reg <= '0;
            move_total_reg    <= '0;
            drop_flag_reg     <= 1'b0;
            pend_reg          <= 1'b0;
            final_reg         <= 1'b0;
            ptr_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            item_count_reg    <= item_count_next;
            compare_total_reg <= compare_total_next;
            move_total_reg    <= move_total_next;
            drop_flag_reg     <= drop_flag_next;
            pend_reg          <= pend_next;
            final_reg         <= final_next;
            ptr_reg           <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= COUNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write to the same entry in one cycle");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (item_count_reg != '0))
        else $error("emission from an empty store");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && m_axis_tlast) |=> (item_count_reg == '0 && !drop_flag_reg))
        else $error("store not cleared after the last transfer");

endmodule
